// ----- rtl/rts_pkg.sv -----
// Shared types and constants for the running temperature statistics unit.
// Used by rts_ctrl, rts_dp and the top level; depends on nothing else.

package rts_pkg;

    // Field widths fixed by the interface.
    localparam int TEMP_W  = 7;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 39;
    localparam int MEAN_W  = 15;

    // Histogram size and fixed-point format of the mean.
    localparam int TEMP_VALUES    = 128;
    localparam int MEAN_FRAC_BITS = 8;
    localparam int HIST_AW        = $clog2(TEMP_VALUES);

    // Divider: the dividend is the sum shifted left by the fraction bits.
    localparam int DIV_W  = SUM_W + MEAN_FRAC_BITS;
    localparam int ITER_W = $clog2(DIV_W + 1);

    // Sample count value at which further readings are dropped.
    localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_OUT
    } t_rts_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take the item and read its histogram entry
        logic update;   // update statistics and start the divider
        logic div_step; // one restoring division step
        logic out_load; // copy results into the output register
    } t_rts_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done; // all quotient bits are computed
    } t_rts_sts;

endpackage

// ----- rtl/rts_ctrl.sv -----
// Controller state machine of the running temperature statistics unit.
// Sequences item intake, update, division and result hand-off; uses rts_pkg.

module rts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  rts_pkg::t_rts_sts   i_sts,
    output rts_pkg::t_rts_cmd   o_cmd
);

    rts_pkg::t_rts_state r_state;
    rts_pkg::t_rts_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    // The output register can take a new item when empty or being emptied.
    assign out_free = !r_out_valid || i_ready;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_ready        = 1'b0;
        case (r_state)
            rts_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rts_pkg::S_UPDATE;
                end
            end
            rts_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = rts_pkg::S_DIV;
            end
            rts_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = rts_pkg::S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            rts_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rts_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid rises on a load and falls when the item is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- rtl/rts_dp.sv -----
// Datapath of the running temperature statistics unit: histogram memory,
// running statistics, restoring divider and output register; uses rts_pkg.

module rts_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rts_pkg::t_rts_cmd                i_cmd,
    output rts_pkg::t_rts_sts                o_sts,
    input  logic [rts_pkg::TEMP_W-1:0]       i_temperature,
    output logic [rts_pkg::TEMP_W-1:0]       o_max_temperature,
    output logic [rts_pkg::TEMP_W-1:0]       o_min_temperature,
    output logic [rts_pkg::MEAN_W-1:0]       o_mean_fixed,
    output logic [rts_pkg::TEMP_W-1:0]       o_mode_temperature,
    output logic [rts_pkg::COUNT_W-1:0]      o_sample_total,
    output logic                             o_dropped
);

    // Histogram memory with per-entry valid bits; invalid entries read as zero.
    logic [rts_pkg::COUNT_W-1:0] r_hist_mem [rts_pkg::TEMP_VALUES];
    logic [rts_pkg::TEMP_VALUES-1:0] r_hist_vld;

    logic [rts_pkg::TEMP_W-1:0]  temp_sat;
    logic [rts_pkg::TEMP_W-1:0]  r_temp;
    logic [rts_pkg::COUNT_W-1:0] r_rd_data;
    logic                        r_rd_vld;

    // Running statistics.
    logic [rts_pkg::COUNT_W-1:0] r_count;
    logic [rts_pkg::SUM_W-1:0]   r_sum;
    logic [rts_pkg::TEMP_W-1:0]  r_lowest;
    logic [rts_pkg::TEMP_W-1:0]  r_highest;
    logic [rts_pkg::TEMP_W-1:0]  r_mode_value;
    logic [rts_pkg::COUNT_W-1:0] r_mode_count;
    logic                        r_drop;

    logic                        drop;
    logic [rts_pkg::COUNT_W-1:0] hist_new;
    logic [rts_pkg::SUM_W-1:0]   n_sum;
    logic [rts_pkg::COUNT_W-1:0] n_count;

    // Divider state.
    logic [rts_pkg::DIV_W-1:0]   r_quo;
    logic [rts_pkg::COUNT_W-1:0] r_rem;
    logic [rts_pkg::ITER_W-1:0]  r_iter;
    logic [rts_pkg::COUNT_W:0]   rem_sh;
    logic [rts_pkg::COUNT_W:0]   rem_diff;
    logic                        quo_bit;

    // Readings beyond the histogram clamp to its last entry.
    assign temp_sat = (32'(i_temperature) >= 32'(rts_pkg::TEMP_VALUES))
                    ? rts_pkg::TEMP_W'(rts_pkg::TEMP_VALUES - 1) : i_temperature;

    // Capture the item and read its histogram entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp    <= temp_sat;
            r_rd_data <= r_hist_mem[rts_pkg::HIST_AW'(temp_sat)];
            r_rd_vld  <= r_hist_vld[rts_pkg::HIST_AW'(temp_sat)];
        end
    end

    // Update values for the captured item.
    assign drop     = (r_count == rts_pkg::COUNT_FULL);
    assign hist_new = (r_rd_vld ? r_rd_data : '0) + rts_pkg::COUNT_W'(1);
    assign n_sum    = drop ? r_sum : r_sum + rts_pkg::SUM_W'(r_temp);
    assign n_count  = drop ? r_count : r_count + rts_pkg::COUNT_W'(1);

    // Histogram write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !drop) begin
            r_hist_mem[rts_pkg::HIST_AW'(r_temp)] <= hist_new;
        end
    end

    // Valid bits of the histogram entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (i_cmd.update && !drop) begin
            r_hist_vld[rts_pkg::HIST_AW'(r_temp)] <= 1'b1;
        end
    end

    // Count, sum, extremes and mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_lowest     <= '1;
            r_highest    <= '0;
            r_mode_value <= '0;
            r_mode_count <= '0;
        end else if (i_cmd.update && !drop) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            if (hist_new > r_mode_count) begin
                r_mode_value <= r_temp;
                r_mode_count <= hist_new;
            end
            if (r_temp > r_highest) begin
                r_highest <= r_temp;
            end
            if (r_temp < r_lowest) begin
                r_lowest <= r_temp;
            end
        end
    end

    // Restoring division step: one quotient bit per cycle.
    assign rem_sh   = {r_rem, r_quo[rts_pkg::DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_count};
    assign quo_bit  = (rem_sh >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_drop <= drop;
            r_quo  <= rts_pkg::DIV_W'(n_sum) << rts_pkg::MEAN_FRAC_BITS;
            r_rem  <= '0;
            r_iter <= rts_pkg::ITER_W'(rts_pkg::DIV_W);
        end else if (i_cmd.div_step && (r_iter != '0)) begin
            r_quo  <= {r_quo[rts_pkg::DIV_W-2:0], quo_bit};
            r_rem  <= quo_bit ? rem_diff[rts_pkg::COUNT_W-1:0]
                              : rem_sh[rts_pkg::COUNT_W-1:0];
            r_iter <= r_iter - rts_pkg::ITER_W'(1);
        end
    end

    assign o_sts.div_done = (r_iter == '0);

    // Output register; an empty tracker reports a zero mean.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_max_temperature  <= r_highest;
            o_min_temperature  <= r_lowest;
            o_mean_fixed       <= (r_count == '0) ? '0 : r_quo[rts_pkg::MEAN_W-1:0];
            o_mode_temperature <= r_mode_value;
            o_sample_total     <= r_count;
            o_dropped          <= r_drop;
        end
    end

endmodule

// ----- rtl/running_temperature_statistics_unit.sv -----
// Top level of the running temperature statistics unit.
// Joins the controller rts_ctrl and the datapath rts_dp; uses rts_pkg.
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------------
//  input     i_valid / o_ready    i_temperature
//  output    o_valid / i_ready    o_max_temperature, o_min_temperature,
//                                 o_mean_fixed, o_mode_temperature,
//                                 o_sample_total, o_dropped
//
// From acceptance to its result in the output register, one item passes through
// a histogram read, an update, and one step per quotient bit of the restoring
// divider that forms the mean. Reset clears the histogram valid bits and all
// statistics at once, so an item may be accepted as soon as reset is released.
// A stalled output holds the next result inside the block until the output
// register frees up.

module running_temperature_statistics_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rts_pkg::TEMP_W-1:0]       i_temperature,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rts_pkg::TEMP_W-1:0]       o_max_temperature,
    output logic [rts_pkg::TEMP_W-1:0]       o_min_temperature,
    output logic [rts_pkg::MEAN_W-1:0]       o_mean_fixed,
    output logic [rts_pkg::TEMP_W-1:0]       o_mode_temperature,
    output logic [rts_pkg::COUNT_W-1:0]      o_sample_total,
    output logic                             o_dropped
);

    rts_pkg::t_rts_cmd cmd;
    rts_pkg::t_rts_sts sts;

    // Controller.
    rts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath.
    rts_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_temperature      (i_temperature),
        .o_max_temperature  (o_max_temperature),
        .o_min_temperature  (o_min_temperature),
        .o_mean_fixed       (o_mean_fixed),
        .o_mode_temperature (o_mode_temperature),
        .o_sample_total     (o_sample_total),
        .o_dropped          (o_dropped)
    );

endmodule
